/* design/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Sizes of the list memory, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package ple_pkg;

    // List capacity (2..64)
    localparam int DEPTH = 32;
    // Entry index width and entry count width
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    // Field widths fixed by the stream format
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 2;
    localparam int TDATA_W  = 40;

    // Operation codes carried in s_tuser
    typedef enum logic [KIND_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5
    } kind_t;

    // Result status codes carried in m_tuser
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_FLUSH,
        ST_INS_PUT,
        ST_DEL_SHIFT,
        ST_DEL_FLUSH,
        ST_DONE
    } state_t;

endpackage

/* design/positional_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_unit: bounded ordered list with positional access
// Keeps up to DEPTH signed 32-bit values in one synchronous RAM and applies
// insert/delete operations at the front, the back or a 1-based position.
// ----------------------------------------------------------------------------
// The list lives in a single-port-read, single-port-write RAM with entry 0 as
// the front, and every insert or delete moves the entries behind the affected
// slot one place, one entry per clock. An insert that must move entries runs
// its shift, flush and put states, an append goes straight to the put state,
// a delete runs its shift and flush states, and a rejected or unknown operation
// goes straight to the done state; the block then returns to idle before the
// next transfer is taken. A front delete from a full list, or a front insert
// with one slot left, is the slowest case. One item is worked on at a time;
// the finished result sits in an output register, so the next item is taken
// while it waits.
module positional_list_engine_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ple_pkg::TDATA_W-1:0]    s_tdata,   // [31:0] value, [38:32] position
    input  logic [ple_pkg::KIND_W-1:0]     s_tuser,   // [2:0] kind
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ple_pkg::TDATA_W-1:0]    m_tdata,   // [31:0] removed_value, [38:32] count_after
    output logic [ple_pkg::STAT_W-1:0]     m_tuser    // [1:0] status
);

    localparam int AW = ple_pkg::AW;
    localparam int CW = ple_pkg::CW;

    // Input field unpacking
    ple_pkg::kind_t                    in_kind;
    logic signed [ple_pkg::VAL_W-1:0]  in_value;
    logic [ple_pkg::POS_W-1:0]         in_pos;

    assign in_kind  = ple_pkg::kind_t'(s_tuser);
    assign in_value = s_tdata[ple_pkg::VAL_W-1:0];
    assign in_pos   = s_tdata[ple_pkg::VAL_W+ple_pkg::POS_W-1:ple_pkg::VAL_W];

    // State and datapath registers
    ple_pkg::state_t                   state_reg, state_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic [AW-1:0]                     ptr_reg, ptr_next;
    logic [AW-1:0]                     base_reg, base_next;
    logic signed [ple_pkg::VAL_W-1:0]  val_reg, val_next;
    logic [AW-1:0]                     rd_addr_reg, rd_addr_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic signed [ple_pkg::VAL_W-1:0]  rd_data_reg;
    logic signed [ple_pkg::VAL_W-1:0]  res_removed_reg, res_removed_next;
    ple_pkg::status_t                  res_status_reg, res_status_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic signed [ple_pkg::VAL_W-1:0]  m_removed_reg, m_removed_next;
    ple_pkg::status_t                  m_status_reg, m_status_next;
    logic [CW-1:0]                     m_count_reg, m_count_next;

    // List memory and its port controls
    logic signed [ple_pkg::VAL_W-1:0]  mem [ple_pkg::DEPTH];
    logic                              rd_en;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [ple_pkg::VAL_W-1:0]  wr_data;

    // Decode of the offered operation
    logic          accept;
    logic          out_free;
    logic          is_full;
    logic          is_empty;
    logic          pos_ok;
    logic          ins_go;
    logic          del_go;
    logic [AW-1:0] ins_idx;
    logic [AW-1:0] del_idx;
    logic [AW-1:0] last_idx;
    ple_pkg::status_t in_status;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_full  = (cnt_reg >= CW'(ple_pkg::DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign pos_ok   = (in_pos != '0) && (in_pos <= ple_pkg::POS_W'(cnt_reg));
    assign last_idx = AW'(cnt_reg - CW'(1));

    // Target slot and immediate status
    always_comb begin
        ins_go    = 1'b0;
        del_go    = 1'b0;
        ins_idx   = '0;
        del_idx   = '0;
        in_status = ple_pkg::STAT_OK;
        case (in_kind) inside
            ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_POS: begin
                if (is_full) begin
                    in_status = ple_pkg::STAT_FULL;
                end else if (in_kind == ple_pkg::OP_INS_FRONT) begin
                    ins_go  = 1'b1;
                    ins_idx = '0;
                end else if (in_kind == ple_pkg::OP_INS_BACK) begin
                    ins_go  = 1'b1;
                    ins_idx = AW'(cnt_reg);
                end else if (!pos_ok) begin
                    in_status = ple_pkg::STAT_BADPOS;
                end else begin
                    ins_go  = 1'b1;
                    ins_idx = AW'(in_pos - ple_pkg::POS_W'(1));
                end
            end
            ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_POS: begin
                if (is_empty) begin
                    in_status = ple_pkg::STAT_EMPTY;
                end else if (in_kind == ple_pkg::OP_DEL_FRONT) begin
                    del_go  = 1'b1;
                    del_idx = '0;
                end else if (in_kind == ple_pkg::OP_DEL_BACK) begin
                    del_go  = 1'b1;
                    del_idx = last_idx;
                end else if (!pos_ok) begin
                    in_status = ple_pkg::STAT_BADPOS;
                end else begin
                    del_go  = 1'b1;
                    del_idx = AW'(in_pos - ple_pkg::POS_W'(1));
                end
            end
            default: begin
                in_status = ple_pkg::STAT_OK;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::ST_IDLE: begin
                if (accept) begin
                    if (ins_go) begin
                        state_next = (cnt_reg > CW'(ins_idx)) ? ple_pkg::ST_INS_SHIFT
                                                              : ple_pkg::ST_INS_PUT;
                    end else if (del_go) begin
                        state_next = ple_pkg::ST_DEL_SHIFT;
                    end else begin
                        state_next = ple_pkg::ST_DONE;
                    end
                end
            end
            ple_pkg::ST_INS_SHIFT: begin
                if (ptr_reg == base_reg) state_next = ple_pkg::ST_INS_FLUSH;
            end
            ple_pkg::ST_INS_FLUSH: state_next = ple_pkg::ST_INS_PUT;
            ple_pkg::ST_INS_PUT:   state_next = ple_pkg::ST_DONE;
            ple_pkg::ST_DEL_SHIFT: begin
                if (ptr_reg == last_idx) state_next = ple_pkg::ST_DEL_FLUSH;
            end
            ple_pkg::ST_DEL_FLUSH: state_next = ple_pkg::ST_DONE;
            ple_pkg::ST_DONE: begin
                if (out_free) state_next = ple_pkg::ST_IDLE;
            end
            default: state_next = ple_pkg::ST_IDLE;
        endcase
    end

    // Outputs: memory port controls and handshake
    always_comb begin
        s_tready = (state_reg == ple_pkg::ST_IDLE);
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = rd_data_reg;
        unique case (state_reg) inside
            ple_pkg::ST_INS_SHIFT, ple_pkg::ST_INS_FLUSH: begin
                // move the entry read last cycle one slot toward the back
                rd_en   = (state_reg == ple_pkg::ST_INS_SHIFT);
                wr_en   = rd_pend_reg;
                wr_addr = AW'(rd_addr_reg + AW'(1));
            end
            ple_pkg::ST_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = base_reg;
                wr_data = val_reg;
            end
            ple_pkg::ST_DEL_SHIFT, ple_pkg::ST_DEL_FLUSH: begin
                // the first read is the removed entry; later ones move forward
                rd_en   = (state_reg == ple_pkg::ST_DEL_SHIFT);
                wr_en   = rd_pend_reg && (rd_addr_reg != base_reg);
                wr_addr = AW'(rd_addr_reg - AW'(1));
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        cnt_next         = cnt_reg;
        ptr_next         = ptr_reg;
        base_next        = base_reg;
        val_next         = val_reg;
        rd_addr_next     = rd_addr_reg;
        rd_pend_next     = 1'b0;
        res_removed_next = res_removed_reg;
        res_status_next  = res_status_reg;
        m_removed_next   = m_removed_reg;
        m_status_next    = m_status_reg;
        m_count_next     = m_count_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;

        case (state_reg) inside
            ple_pkg::ST_IDLE: begin
                if (accept) begin
                    base_next        = ins_go ? ins_idx : del_idx;
                    ptr_next         = ins_go ? last_idx : del_idx;
                    val_next         = in_value;
                    res_removed_next = '0;
                    res_status_next  = in_status;
                end
            end
            ple_pkg::ST_INS_SHIFT: begin
                rd_addr_next = ptr_reg;
                rd_pend_next = 1'b1;
                if (ptr_reg != base_reg) ptr_next = AW'(ptr_reg - AW'(1));
            end
            ple_pkg::ST_INS_PUT: begin
                cnt_next = CW'(cnt_reg + CW'(1));
            end
            ple_pkg::ST_DEL_SHIFT, ple_pkg::ST_DEL_FLUSH: begin
                if (rd_pend_reg && (rd_addr_reg == base_reg)) begin
                    res_removed_next = rd_data_reg;
                end
                if (state_reg == ple_pkg::ST_DEL_SHIFT) begin
                    rd_addr_next = ptr_reg;
                    rd_pend_next = 1'b1;
                    if (ptr_reg != last_idx) ptr_next = AW'(ptr_reg + AW'(1));
                end else begin
                    cnt_next = CW'(cnt_reg - CW'(1));
                end
            end
            ple_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_removed_next = res_removed_reg;
                    m_status_next  = res_status_reg;
                    m_count_next   = cnt_reg;
                end
            end
            default: begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ple_pkg::ST_IDLE;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ptr_reg         <= ptr_next;
        base_reg        <= base_next;
        val_reg         <= val_next;
        rd_addr_reg     <= rd_addr_next;
        res_removed_reg <= res_removed_next;
        res_status_reg  <= res_status_next;
        m_removed_reg   <= m_removed_next;
        m_status_reg    <= m_status_next;
        m_count_reg     <= m_count_next;
    end

    // List memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[ptr_reg];
    end

    // Result stream
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(ple_pkg::TDATA_W - ple_pkg::VAL_W - ple_pkg::POS_W){1'b0}},
                       ple_pkg::POS_W'(m_count_reg), m_removed_reg};
    assign m_tuser  = m_status_reg;

`ifndef ASSERT_OFF
    // Count never exceeds capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(ple_pkg::DEPTH))
        else $error("entry count above capacity");

    // Count moves by at most one per cycle
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |->
            (cnt_reg == CW'($past(cnt_reg) + CW'(1)) ||
             cnt_reg == CW'($past(cnt_reg) - CW'(1))))
        else $error("entry count jumped");

    // A shift write never hits the entry being read in the same cycle
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != ptr_reg))
        else $error("memory read and write collide");

    // A new result is only loaded from the done state
    a_res_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> ($past(state_reg) == ple_pkg::ST_DONE))
        else $error("result raised outside done state");

    // A full status always reports a full list
    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg == ple_pkg::STAT_FULL) |->
            (m_count_reg == CW'(ple_pkg::DEPTH)))
        else $error("full status with list not full");
`endif

endmodule

/* dv/positional_list_engine_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb: self-checking bench for the list engine
// Sends insert/delete transfers on the input stream, keeps a queue-based copy
// of the list to predict each result, and checks every result transfer field
// by field. A short table of directed operations is followed by random
// traffic that swings between growing, shrinking and mixed phases, under
// three idle patterns on the two streams.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;

    localparam int CNT_W      = 7;
    localparam int QUIET_MAX  = 4000;                // cycles with no transfer before giving up
    localparam int DRAIN_WAIT = ple_pkg::DEPTH + 8;  // worst op latency plus margin
    localparam int RAND_ITEMS = 276;                 // random transfers per idle phase
    localparam int SEG_LEN    = 60;                  // length of one grow/shrink/mix segment
    localparam int NUM_DIR    = 24;
    localparam int MAX_REPORT = 10;

    // Kind codes outside the defined operations; the block leaves the list unchanged and reports ok
    localparam logic [ple_pkg::KIND_W-1:0] KIND_RSVD_6 = 3'd6;
    localparam logic [ple_pkg::KIND_W-1:0] KIND_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [ple_pkg::VAL_W-1:0] removed;
        ple_pkg::status_t          status;
        logic [CNT_W-1:0]          count;
    } list_outcome_t;

    typedef struct packed {
        logic [ple_pkg::KIND_W-1:0] op;
        logic [ple_pkg::VAL_W-1:0]  val;
        logic [ple_pkg::POS_W-1:0]  pos;
        bit                         typed;
        logic [ple_pkg::VAL_W-1:0]  x_removed;
        ple_pkg::status_t           x_status;
        logic [CNT_W-1:0]           x_count;
    } dir_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ple_pkg::TDATA_W-1:0]   s_tdata;
    logic [ple_pkg::KIND_W-1:0]    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ple_pkg::TDATA_W-1:0]   m_tdata;
    logic [ple_pkg::STAT_W-1:0]    m_tuser;

    // Predicted list contents, front at index 0
    logic [ple_pkg::VAL_W-1:0]     list_store[$];
    list_outcome_t                 pending_outcomes[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned quiet_cycles;
    int unsigned peak_count;
    int unsigned status_seen[4];

    dir_row_t          dir_table[NUM_DIR];
    ple_pkg::kind_t    ins_ops[3] = '{ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK,
                                      ple_pkg::OP_INS_POS};
    ple_pkg::kind_t    del_ops[3] = '{ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK,
                                      ple_pkg::OP_DEL_POS};

    positional_list_engine_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] value, [38:32] position
        .s_tuser  (s_tuser),    // [2:0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [31:0] removed_value, [38:32] count_after
        .m_tuser  (m_tuser)     // [1:0] status
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Apply one operation to the predicted list and return its outcome
    function automatic list_outcome_t apply_list_op(logic [ple_pkg::KIND_W-1:0] op,
                                                    logic [ple_pkg::VAL_W-1:0] val,
                                                    logic [ple_pkg::POS_W-1:0] pos);
        list_outcome_t r;
        int unsigned   n;
        r = '0;
        r.status = ple_pkg::STAT_OK;
        n = list_store.size();
        case (op) inside
            ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_POS: begin
                // full check wins over the position check
                if (n >= ple_pkg::DEPTH)
                    r.status = ple_pkg::STAT_FULL;
                else if (op == ple_pkg::OP_INS_FRONT)
                    list_store.push_front(val);
                else if (op == ple_pkg::OP_INS_BACK)
                    list_store.push_back(val);
                else if (pos < 1 || pos > n)
                    r.status = ple_pkg::STAT_BADPOS;
                else
                    list_store.insert(pos - 1, val);
            end
            ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_POS: begin
                // empty check wins over the position check
                if (n == 0)
                    r.status = ple_pkg::STAT_EMPTY;
                else if (op == ple_pkg::OP_DEL_FRONT)
                    r.removed = list_store.pop_front();
                else if (op == ple_pkg::OP_DEL_BACK)
                    r.removed = list_store.pop_back();
                else if (pos < 1 || pos > n)
                    r.status = ple_pkg::STAT_BADPOS;
                else begin
                    r.removed = list_store[pos - 1];
                    list_store.delete(pos - 1);
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(list_store.size());
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_op(input logic [ple_pkg::KIND_W-1:0] op,
                           input logic [ple_pkg::VAL_W-1:0] val,
                           input logic [ple_pkg::POS_W-1:0] pos, input bit typed,
                           input list_outcome_t typed_out);
        list_outcome_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, pos, val};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_list_op(op, val, pos);
        pending_outcomes.push_back(typed ? typed_out : predicted);
        status_seen[predicted.status]++;
        items_sent++;
        if (list_store.size() > peak_count)
            peak_count = list_store.size();
        @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input logic [ple_pkg::VAL_W-1:0] want,
                                 input logic [ple_pkg::VAL_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORT)
            $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, what, want, got);
    endtask

    // Receiver backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        list_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_outcomes.size() == 0) begin
                note_mismatch("unexpected result transfer", '0,
                              m_tdata[ple_pkg::VAL_W-1:0]);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tdata[ple_pkg::VAL_W-1:0] !== want.removed)
                    note_mismatch("removed_value", want.removed,
                                  m_tdata[ple_pkg::VAL_W-1:0]);
                if (m_tuser !== want.status)
                    note_mismatch("status", want.status, m_tuser);
                if (m_tdata[ple_pkg::VAL_W+CNT_W-1:ple_pkg::VAL_W] !== want.count)
                    note_mismatch("count_after", want.count,
                                  m_tdata[ple_pkg::VAL_W+CNT_W-1:ple_pkg::VAL_W]);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     QUIET_MAX, pending_outcomes.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        logic [ple_pkg::KIND_W-1:0] op;
        logic [ple_pkg::VAL_W-1:0]  val;
        logic [ple_pkg::POS_W-1:0]  pos;
        int unsigned                n;
        int unsigned                roll;
        int unsigned                ins_pct;
        list_outcome_t              typed_out;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ple_pkg::OP_INS_FRONT;
        send_idle_pct = 7;
        recv_idle_pct = 75;
        items_sent    = 0;
        peak_count    = 0;
        status_seen   = '{0, 0, 0, 0};

        // op, value, position, typed, removed, status, count
        dir_table = '{
            '{ple_pkg::OP_DEL_FRONT, 32'h0000_0000, 7'd0, 1'b1, '0, ple_pkg::STAT_EMPTY, 7'd0},
            '{ple_pkg::OP_DEL_BACK, 32'h0000_0000, 7'd0, 1'b1, '0, ple_pkg::STAT_EMPTY, 7'd0},
            '{ple_pkg::OP_DEL_POS, 32'h0000_0000, 7'd1, 1'b1, '0, ple_pkg::STAT_EMPTY, 7'd0},
            '{ple_pkg::OP_INS_POS, 32'h1234_5678, 7'd1, 1'b1, '0, ple_pkg::STAT_BADPOS, 7'd0},
            '{KIND_RSVD_6, 32'hFFFF_FFFF, 7'd64, 1'b1, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_INS_FRONT, 32'h7FFF_FFFF, 7'd0, 1'b1, '0, ple_pkg::STAT_OK, 7'd1},
            '{ple_pkg::OP_INS_BACK, 32'h8000_0000, 7'd64, 1'b1, '0, ple_pkg::STAT_OK, 7'd2},
            '{ple_pkg::OP_INS_POS, 32'hA5A5_A5A5, 7'd0, 1'b1, '0, ple_pkg::STAT_BADPOS, 7'd2},
            '{ple_pkg::OP_INS_POS, 32'hA5A5_A5A5, 7'd3, 1'b1, '0, ple_pkg::STAT_BADPOS, 7'd2},
            '{ple_pkg::OP_INS_POS, 32'hFFFF_FFFF, 7'd2, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_INS_POS, 32'h0000_0000, 7'd1, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_INS_POS, 32'h5A5A_5A5A, 7'd4, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{KIND_RSVD_7, 32'h0000_0001, 7'd3, 1'b1, '0, ple_pkg::STAT_OK, 7'd5},
            '{ple_pkg::OP_DEL_POS, 32'h0000_0000, 7'd64, 1'b1, '0, ple_pkg::STAT_BADPOS, 7'd5},
            '{ple_pkg::OP_DEL_POS, 32'h0000_0000, 7'd0, 1'b1, '0, ple_pkg::STAT_BADPOS, 7'd5},
            '{ple_pkg::OP_DEL_POS, 32'h0000_0000, 7'd6, 1'b1, '0, ple_pkg::STAT_BADPOS, 7'd5},
            '{ple_pkg::OP_DEL_POS, 32'hFFFF_FFFF, 7'd5, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_DEL_POS, 32'h0000_0000, 7'd2, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_DEL_FRONT, 32'h0000_0000, 7'd0, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_DEL_BACK, 32'h0000_0000, 7'd0, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_DEL_POS, 32'h0000_0000, 7'd1, 1'b0, '0, ple_pkg::STAT_OK, 7'd0},
            '{ple_pkg::OP_DEL_BACK, 32'h0000_0000, 7'd0, 1'b1, '0, ple_pkg::STAT_EMPTY, 7'd0},
            '{ple_pkg::OP_INS_BACK, 32'h0000_0001, 7'd0, 1'b1, '0, ple_pkg::STAT_OK, 7'd1},
            '{ple_pkg::OP_DEL_FRONT, 32'h0000_0000, 7'd0, 1'b1, 32'd1, ple_pkg::STAT_OK, 7'd0}
        };

        // Reset
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < 3; phase++) begin
            // sender mostly busy / receiver mostly busy / no idling
            send_idle_pct = (phase == 0) ? 7  : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 7  : 0;

            if (phase == 0) begin
                foreach (dir_table[r]) begin
                    typed_out = '{dir_table[r].x_removed, dir_table[r].x_status,
                                  dir_table[r].x_count};
                    send_op(dir_table[r].op, dir_table[r].val, dir_table[r].pos,
                            dir_table[r].typed, typed_out);
                end
            end

            for (int i = 0; i < RAND_ITEMS; i++) begin
                // segments drive the list toward full, toward empty, or hold it
                case ((i / SEG_LEN) % 3)
                    0: ins_pct = 85;
                    1: ins_pct = 15;
                    default: ins_pct = 50;
                endcase
                roll = $urandom_range(99);
                if (roll < 2)
                    op = $urandom_range(1) ? KIND_RSVD_6 : KIND_RSVD_7;
                else if (roll < 2 + ins_pct)
                    op = ins_ops[$urandom_range(2)];
                else
                    op = del_ops[$urandom_range(2)];

                // mostly valid positions, sometimes anywhere from 0 to 64
                n = list_store.size();
                if (n > 0 && $urandom_range(99) < 80)
                    pos = ple_pkg::POS_W'($urandom_range(n, 1));
                else
                    pos = ple_pkg::POS_W'($urandom_range(64));

                case ($urandom_range(7))
                    0: val = 32'h7FFF_FFFF;
                    1: val = 32'h8000_0000;
                    2: val = {{28{1'b1}}, 4'($urandom_range(15))};
                    3: val = 32'($urandom_range(15));
                    default: val = $urandom;
                endcase
                send_op(op, val, pos, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray results
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d operations, checked %0d results, peak list size %0d of %0d.",
                 items_sent, results_checked, peak_count, ple_pkg::DEPTH);
        $display("Outcomes: ok %0d, full %0d, empty %0d, bad position %0d; mismatches %0d.",
                 status_seen[ple_pkg::STAT_OK], status_seen[ple_pkg::STAT_FULL],
                 status_seen[ple_pkg::STAT_EMPTY], status_seen[ple_pkg::STAT_BADPOS],
                 mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
